/* src/rpi_pkg.sv */
// Shared constants, types and helpers for the ray/primitive intersection unit.
`default_nettype none
package rpi_pkg;
	localparam int CW    = 21;           // coordinate width actually used
	localparam int FW    = 21;           // coordinate field width on the ports
	localparam int TW    = 31;           // t_min/t_max width
	localparam int OW    = 32;           // hit_time width
	localparam int RGW   = 63;           // packed xyz register width
	localparam int RADW  = 20;
	localparam int DATW  = 64;
	localparam int PAW   = 6;
	localparam int DW    = CW + 1;       // coordinate differences
	localparam int PW    = 2 * DW + 1;   // 2x2 minors
	localparam int MW    = DW + PW + 2;  // determinants
	localparam int SW    = 2 * DW + 3;   // sphere b, |d|^2, c
	localparam int DSW   = 2 * SW + 2;   // discriminant, even
	localparam int RW    = DSW / 2;      // square root bits
	localparam int SPL   = (SW + 1) / 2; // low part of split multiplies
	localparam int NW    = MW;           // divider operand width
	localparam int FRACB = 16;
	localparam int QB    = 33;           // quotient bits before saturation
	localparam int XW    = NW + QB + 1;
	localparam int QD    = 4;            // queue depth
	localparam int QAW   = 2;

	localparam logic [OW-1:0] MISS_TIME = 32'hFFFF0000;
	localparam logic [OW-1:0] T_MAX_POS = 32'h7FFFFFFF;
	localparam logic [OW-1:0] T_MIN_NEG = 32'h80000000;

	typedef enum logic [2:0] {
		REG_KIND, REG_VA, REG_VB, REG_VC, REG_CTR, REG_RAD
	} rpi_reg_t;

	typedef struct packed {
		logic            kind;   // 1 triangle, 0 sphere
		logic [RGW-1:0]  va;
		logic [RGW-1:0]  vb;
		logic [RGW-1:0]  vc;
		logic [RGW-1:0]  ctr;
		logic [RADW-1:0] rad;
	} rpi_cfg_t;

	// one division job handed from front to back
	typedef struct packed {
		logic          is_tri;
		logic          ok;
		logic          neg;
		logic [NW-1:0] mag;
		logic [NW-1:0] den;
		logic [TW-1:0] tmin;
		logic [TW-1:0] tmax;
	} rpi_job_t;

	function automatic logic signed [DW-1:0] sx(input logic [FW-1:0] v);
		sx = {{(DW-CW){v[CW-1]}}, v[CW-1:0]};
	endfunction

	function automatic logic signed [DW-1:0] comp(input logic [RGW-1:0] r, input int k);
		logic [CW-1:0] c;
		c = r[k*CW +: CW];
		comp = {{(DW-CW){c[CW-1]}}, c};
	endfunction
endpackage
`default_nettype wire

/* src/rpi_if.sv */
// Ray and hit channel interfaces.
`default_nettype none
interface rpi_ray_if import rpi_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [FW-1:0] origin_x;
	logic signed [FW-1:0] origin_y;
	logic signed [FW-1:0] origin_z;
	logic signed [FW-1:0] dir_x;
	logic signed [FW-1:0] dir_y;
	logic signed [FW-1:0] dir_z;
	logic [TW-1:0]        t_min;
	logic [TW-1:0]        t_max;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, output ready);
endinterface

interface rpi_hit_if import rpi_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic signed [OW-1:0] hit_time;
	modport source(output valid, hit, hit_time, input ready);
	modport sink(input valid, hit, hit_time, output ready);
endinterface
`default_nettype wire

/* src/ray_primitive_intersection_unit.sv */
// Throughput: one ray per cycle unless a full queue or a stalled receiver holds it;
// set by the square root line in the front (one root bit per stage) and the divider
// in the back (one quotient bit per stage).
// Front and back stall on their own; a 4-word queue sits between them.
// Reset (arst_n, async low) clears all valid bits, queue and config registers.
// Configuration must be written only while no ray is in flight.
`default_nettype none
module ray_primitive_intersection_unit import rpi_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [PAW-1:0]  paddr,
	input  wire logic [DATW-1:0] pwdata,
	output logic [DATW-1:0]      prdata,
	output logic                 pready,
	rpi_ray_if.sink              ray,
	rpi_hit_if.source            res
);
	rpi_cfg_t cfg_q;
	logic     wr;
	logic     push, full, pop, avail;
	rpi_job_t job_f, job_b;
	rpi_reg_t ra;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign ra = rpi_reg_t'(paddr[PAW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (ra)
				REG_KIND: cfg_q.kind <= pwdata[0];
				REG_VA:   cfg_q.va <= pwdata[RGW-1:0];
				REG_VB:   cfg_q.vb <= pwdata[RGW-1:0];
				REG_VC:   cfg_q.vc <= pwdata[RGW-1:0];
				REG_CTR:  cfg_q.ctr <= pwdata[RGW-1:0];
				REG_RAD:  cfg_q.rad <= pwdata[RADW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ra)
			REG_KIND: prdata = {{(DATW-1){1'b0}}, cfg_q.kind};
			REG_VA:   prdata = {{(DATW-RGW){1'b0}}, cfg_q.va};
			REG_VB:   prdata = {{(DATW-RGW){1'b0}}, cfg_q.vb};
			REG_VC:   prdata = {{(DATW-RGW){1'b0}}, cfg_q.vc};
			REG_CTR:  prdata = {{(DATW-RGW){1'b0}}, cfg_q.ctr};
			REG_RAD:  prdata = {{(DATW-RADW){1'b0}}, cfg_q.rad};
			default:  prdata = '0;
		endcase
	end

	rpi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ray    (ray),
		.full   (full),
		.push   (push),
		.job    (job_f)
	);

	rpi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_f),
		.full   (full),
		.pop    (pop),
		.avail  (avail),
		.dout   (job_b)
	);

	rpi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.job    (job_b),
		.pop    (pop),
		.res    (res)
	);
endmodule
`default_nettype wire

/* src/rpi_front.sv */
// Front: accepts rays, forms determinants or discriminant and root, emits division jobs.
`default_nettype none
module rpi_front import rpi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rpi_cfg_t cfg,
	rpi_ray_if.sink       ray,
	input  wire logic     full,
	output logic          push,
	output rpi_job_t      job
);
	typedef struct packed {
		logic                 is_tri;
		logic                 tri_ok;
		logic signed [MW-1:0] tn;
		logic [MW-1:0]        m;
		logic signed [SW-1:0] bp;
		logic [SW-1:0]        dd;
		logic                 dneg;
		logic                 dzero;
		logic [TW-1:0]        tmin;
		logic [TW-1:0]        tmax;
	} rpi_car_t;

	logic en;
	logic v_s1, v_s2, v_s3, v_q;

	// stage 1: differences
	logic signed [DW-1:0] ab_s1 [3], ac_s1 [3], dv_s1 [3], ao_s1 [3], ex_s1 [3];
	logic [TW-1:0] tmin_s1, tmax_s1;
	// stage 2: minors and sphere terms
	logic signed [PW-1:0] x_s2 [3], y_s2 [3];
	logic signed [DW-1:0] ab_s2 [3], ac_s2 [3], dv_s2 [3], ao_s2 [3];
	logic signed [SW-1:0] bp_s2, dd_s2, cc_s2;
	logic [TW-1:0] tmin_s2, tmax_s2;
	// stage 3: determinants and split products
	logic signed [MW-1:0] m_s3, tn_s3, gn_s3, bn_s3;
	logic signed [DSW-1:0] pbl_s3, pbh_s3, pcl_s3, pch_s3;
	logic signed [SW-1:0] bp_s3, dd_s3;
	logic [TW-1:0] tmin_s3, tmax_s3;
	// square root line, index 0 is stage 4
	logic [DSW-1:0] op_s [RW+1];
	logic [DSW-1:0] res_s [RW+1];
	rpi_car_t       car_s [RW+1];
	logic           v_s [RW+1];
	rpi_job_t       job_q;

	assign en = !(v_q && full);
	assign ray.ready = en;
	assign push = v_q && !full;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s[0] <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s[0] <= v_s3;
			v_q <= v_s[RW];
		end
	end

	logic signed [DW-1:0] o_c [3], d_c [3];
	always_comb begin
		o_c[0] = sx(ray.origin_x);
		o_c[1] = sx(ray.origin_y);
		o_c[2] = sx(ray.origin_z);
		d_c[0] = sx(ray.dir_x);
		d_c[1] = sx(ray.dir_y);
		d_c[2] = sx(ray.dir_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 3; n++) begin
				ab_s1[n] <= comp(cfg.va, n) - comp(cfg.vb, n);
				ac_s1[n] <= comp(cfg.va, n) - comp(cfg.vc, n);
				dv_s1[n] <= d_c[n];
				ao_s1[n] <= comp(cfg.va, n) - o_c[n];
				ex_s1[n] <= o_c[n] - comp(cfg.ctr, n);
			end
			tmin_s1 <= ray.t_min;
			tmax_s1 <= ray.t_max;
		end
	end

	logic signed [DW-1:0] rad_c;
	assign rad_c = {{(DW-CW+1){1'b0}}, cfg.rad[CW-2:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2[0] <= ac_s1[1] * dv_s1[2] - dv_s1[1] * ac_s1[2];
			x_s2[1] <= dv_s1[0] * ac_s1[2] - ac_s1[0] * dv_s1[2];
			x_s2[2] <= ac_s1[0] * dv_s1[1] - ac_s1[1] * dv_s1[0];
			y_s2[0] <= ab_s1[0] * ao_s1[1] - ao_s1[0] * ab_s1[1];
			y_s2[1] <= ao_s1[0] * ab_s1[2] - ab_s1[0] * ao_s1[2];
			y_s2[2] <= ab_s1[1] * ao_s1[2] - ao_s1[1] * ab_s1[2];
			ab_s2 <= ab_s1;
			ac_s2 <= ac_s1;
			dv_s2 <= dv_s1;
			ao_s2 <= ao_s1;
			bp_s2 <= dv_s1[0] * ex_s1[0] + dv_s1[1] * ex_s1[1] + dv_s1[2] * ex_s1[2];
			dd_s2 <= dv_s1[0] * dv_s1[0] + dv_s1[1] * dv_s1[1] + dv_s1[2] * dv_s1[2];
			cc_s2 <= ex_s1[0] * ex_s1[0] + ex_s1[1] * ex_s1[1] + ex_s1[2] * ex_s1[2]
				- rad_c * rad_c;
			tmin_s2 <= tmin_s1;
			tmax_s2 <= tmax_s1;
		end
	end

	// products in the discriminant are split so each multiply stays near 24x48
	logic signed [SPL:0]      bpl_c, ccl_c;
	logic signed [SW-SPL-1:0] bph_c, cch_c;
	assign bpl_c = {1'b0, bp_s2[SPL-1:0]};
	assign bph_c = bp_s2[SW-1:SPL];
	assign ccl_c = {1'b0, cc_s2[SPL-1:0]};
	assign cch_c = cc_s2[SW-1:SPL];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3  <= ab_s2[0] * x_s2[0] + ab_s2[1] * x_s2[1] + ab_s2[2] * x_s2[2];
			tn_s3 <= -(ac_s2[2] * y_s2[0] + ac_s2[1] * y_s2[1] + ac_s2[0] * y_s2[2]);
			gn_s3 <= dv_s2[2] * y_s2[0] + dv_s2[1] * y_s2[1] + dv_s2[0] * y_s2[2];
			bn_s3 <= ao_s2[0] * x_s2[0] + ao_s2[1] * x_s2[1] + ao_s2[2] * x_s2[2];
			pbl_s3 <= bp_s2 * bpl_c;
			pbh_s3 <= bp_s2 * bph_c;
			pcl_s3 <= dd_s2 * ccl_c;
			pch_s3 <= dd_s2 * cch_c;
			bp_s3 <= bp_s2;
			dd_s3 <= dd_s2;
			tmin_s3 <= tmin_s2;
			tmax_s3 <= tmax_s2;
		end
	end

	// stage 4: sign normalize, barycentric tests, discriminant
	logic                  mneg_c;
	logic signed [MW-1:0]  mp_c, tp_c, gp_c, bq_c;
	logic signed [MW:0]    gb_c;
	logic signed [DSW-1:0] disc_c;
	rpi_car_t              car_c;
	always_comb begin
		mneg_c = m_s3 < 0;
		mp_c = mneg_c ? -m_s3 : m_s3;
		tp_c = mneg_c ? -tn_s3 : tn_s3;
		gp_c = mneg_c ? -gn_s3 : gn_s3;
		bq_c = mneg_c ? -bn_s3 : bn_s3;
		gb_c = gp_c + bq_c;
		disc_c = ((pbh_s3 <<< SPL) + pbl_s3) - ((pch_s3 <<< SPL) + pcl_s3);
		car_c.is_tri = cfg.kind;
		car_c.tri_ok = (m_s3 != 0) && !(gp_c < 0) && !(gp_c > mp_c) && !(bq_c < 0)
			&& !(gb_c > mp_c);
		car_c.tn = tp_c;
		car_c.m = mp_c;
		car_c.bp = bp_s3;
		car_c.dd = dd_s3;
		car_c.dneg = disc_c < 0;
		car_c.dzero = disc_c == 0;
		car_c.tmin = tmin_s3;
		car_c.tmax = tmax_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0] <= disc_c < 0 ? '0 : disc_c;
			res_s[0] <= '0;
			car_s[0] <= car_c;
		end
	end

	// one result bit of the square root per stage
	for (genvar k = 0; k < RW; k++) begin : g_sq
		localparam logic [DSW-1:0] ONE = {{(DSW-1){1'b0}}, 1'b1} << (DSW - 2 - 2 * k);
		logic [DSW-1:0] trial;
		logic           take;
		always_comb begin
			trial = res_s[k] + ONE;
			take = op_s[k] >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k+1] <= take ? op_s[k] - trial : op_s[k];
				res_s[k+1] <= take ? (res_s[k] >> 1) + ONE : res_s[k] >> 1;
				car_s[k+1] <= car_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	// root choice and job build
	rpi_car_t              cf;
	logic signed [SW+2:0]  nb_c, sr_c, n1_c, n2_c;
	logic signed [NW-1:0]  num_c;
	rpi_job_t              job_c;
	always_comb begin
		cf = car_s[RW];
		nb_c = -{{3{cf.bp[SW-1]}}, cf.bp};
		sr_c = {2'b00, res_s[RW][RW-1:0]};
		n1_c = nb_c - sr_c;
		n2_c = nb_c + sr_c;
		job_c.is_tri = cf.is_tri;
		job_c.tmin = cf.tmin;
		job_c.tmax = cf.tmax;
		if (cf.is_tri) begin
			job_c.ok = cf.tri_ok;
			num_c = cf.tn;
			job_c.den = cf.m;
		end else begin
			job_c.ok = (cf.dd != 0) && !cf.dneg && (cf.dzero || n1_c > 0 || n2_c > 0);
			if (cf.dzero) begin
				num_c = NW'(nb_c);
			end else if (n1_c > 0) begin
				num_c = NW'(n1_c);
			end else begin
				num_c = NW'(n2_c);
			end
			job_c.den = {{(NW-SW){1'b0}}, cf.dd};
		end
		job_c.neg = num_c < 0;
		job_c.mag = job_c.neg ? -num_c : num_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_q <= job_c;
		end
	end
endmodule
`default_nettype wire

/* src/rpi_fifo.sv */
// Short job queue between front and back.
`default_nettype none
module rpi_fifo import rpi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rpi_job_t din,
	output logic          full,
	input  wire logic     pop,
	output logic          avail,
	output rpi_job_t      dout
);
	rpi_job_t       mem_q [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign full = cnt_q == (QAW+1)'(QD);
	assign avail = cnt_q != '0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QD)) else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("word pushed into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("word popped from empty queue");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("queue count lost");
endmodule
`default_nettype wire

/* src/rpi_back.sv */
// Back: pipelined restoring divider, saturation, window test and result register.
`default_nettype none
module rpi_back import rpi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     avail,
	input  wire rpi_job_t job,
	output logic          pop,
	rpi_hit_if.source     res
);
	typedef struct packed {
		logic          is_tri;
		logic          ok;
		logic          neg;
		logic          ovf;
		logic [TW-1:0] tmin;
		logic [TW-1:0] tmax;
	} rpi_ctl_t;

	logic en;
	logic [XW-1:0] rem_s [QB+1];
	logic [NW-1:0] den_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	rpi_ctl_t      ctl_s [QB+1];
	logic          v_s [QB+1];
	logic          vo_q, hit_q;
	logic [OW-1:0] time_q;

	assign en = !(vo_q && !res.ready);
	assign pop = avail && en;
	assign res.valid = vo_q;
	assign res.hit = hit_q;
	assign res.hit_time = time_q;

	// quotient of 2^QB or more saturates either way
	logic     ovf_c;
	rpi_ctl_t ctl_c;
	always_comb begin
		ovf_c = {{(XW-NW){1'b0}}, job.mag} >= ({{(XW-NW){1'b0}}, job.den} << (QB - FRACB));
		ctl_c.is_tri = job.is_tri;
		ctl_c.ok = job.ok;
		ctl_c.neg = job.neg;
		ctl_c.ovf = ovf_c;
		ctl_c.tmin = job.tmin;
		ctl_c.tmax = job.tmax;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {{(XW-NW){1'b0}}, job.mag} << FRACB;
			den_s[0] <= job.den;
			q_s[0] <= '0;
			ctl_s[0] <= ctl_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [XW-1:0] sub;
		logic          take;
		always_comb begin
			sub = {{(XW-NW){1'b0}}, den_s[k]} << SH;
			take = rem_s[k] >= sub;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - sub : rem_s[k];
				q_s[k+1] <= q_s[k] | (QB'(take) << SH);
				den_s[k+1] <= den_s[k];
				ctl_s[k+1] <= ctl_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	rpi_ctl_t             cl;
	logic [QB-1:0]        q;
	logic                 satp_c, satn_c, hit_c;
	logic signed [OW-1:0] tv_c;
	logic signed [OW:0]   tv_x, lo_x, hi_x;
	always_comb begin
		cl = ctl_s[QB];
		q = q_s[QB];
		satp_c = cl.ovf || q[QB-1] || q[QB-2];
		satn_c = cl.ovf || q[QB-1] || (q[QB-2] && (q[QB-3:0] != '0));
		if (cl.neg) begin
			tv_c = satn_c ? T_MIN_NEG : -q[OW-1:0];
		end else begin
			tv_c = satp_c ? T_MAX_POS : q[OW-1:0];
		end
		tv_x = {tv_c[OW-1], tv_c};
		lo_x = {2'b00, cl.tmin};
		hi_x = {2'b00, cl.tmax};
		hit_c = cl.ok && (!cl.is_tri || (tv_x >= lo_x && tv_x <= hi_x));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_c;
			time_q <= hit_c ? tv_c : MISS_TIME;
		end
	end
endmodule
`default_nettype wire

/* tb/tb_rpi_checker.sv */
// Checker for the intersection unit: mirrors the config bus, predicts each hit word, compares.
module tb_rpi_checker import rpi_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [PAW-1:0]  paddr,
	input  wire logic [DATW-1:0] pwdata,
	input  wire logic            pready,
	rpi_ray_if                   ray,
	rpi_hit_if                   res,
	output int                   errors,
	output int                   pending,
	output int                   hits_seen,
	output int                   rays_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        hit;
		logic [31:0] t;
	} hit_word_t;

	hit_word_t hit_q[$];

	logic            cfg_kind;
	logic [RGW-1:0]  cfg_va, cfg_vb, cfg_vc, cfg_ctr;
	logic [RADW-1:0] cfg_rad;

	function automatic logic signed [127:0] wide(input longint v);
		wide = 128'(v);
	endfunction

	function automatic longint coord(input logic [RGW-1:0] r, input int k);
		logic signed [20:0] c;
		c = r[k*21 +: 21];
		coord = longint'(c);
	endfunction

	// Q15.16 of num/den, den > 0, truncated toward zero, saturated
	function automatic longint q16_wide(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic        neg;
		logic [127:0] mag, d, q;
		neg = num < 0;
		mag = neg ? -num : num;
		mag = mag << 16;
		d = den;
		q = mag / d;
		if (neg) begin
			if (q > 128'h80000000) return -64'sd2147483648;
			return -longint'(q[63:0]);
		end
		if (q > 128'h7FFFFFFF) return 64'sd2147483647;
		return longint'(q[63:0]);
	endfunction

	function automatic longint q16_short(input longint num, input longint den);
		longint q;
		q = (num * 65536) / den;
		if (q > 64'sd2147483647) return 64'sd2147483647;
		if (q < -64'sd2147483648) return -64'sd2147483648;
		return q;
	endfunction

	function automatic longint root_floor(input logic signed [127:0] v);
		longint res_v, cand;
		res_v = 0;
		for (int b = 46; b >= 0; b--) begin
			cand = res_v | (64'sd1 << b);
			if (wide(cand) * wide(cand) <= v) res_v = cand;
		end
		return res_v;
	endfunction

	function automatic bit triangle_hit(input longint o[3], input longint dv[3],
			input longint tmin, input longint tmax, output longint t);
		longint a1, b1, c1, d, e, f, g, h, i, j, k, l;
		longint ei_hf, gf_di, dh_eg, ak_jb, jc_al, bl_kc;
		logic signed [127:0] m, tn, gn, bn;
		a1 = coord(cfg_va, 0) - coord(cfg_vb, 0);
		b1 = coord(cfg_va, 1) - coord(cfg_vb, 1);
		c1 = coord(cfg_va, 2) - coord(cfg_vb, 2);
		d = coord(cfg_va, 0) - coord(cfg_vc, 0);
		e = coord(cfg_va, 1) - coord(cfg_vc, 1);
		f = coord(cfg_va, 2) - coord(cfg_vc, 2);
		g = dv[0]; h = dv[1]; i = dv[2];
		j = coord(cfg_va, 0) - o[0];
		k = coord(cfg_va, 1) - o[1];
		l = coord(cfg_va, 2) - o[2];
		ei_hf = e * i - h * f; gf_di = g * f - d * i; dh_eg = d * h - e * g;
		ak_jb = a1 * k - j * b1; jc_al = j * c1 - a1 * l; bl_kc = b1 * l - k * c1;
		m = wide(a1) * wide(ei_hf) + wide(b1) * wide(gf_di) + wide(c1) * wide(dh_eg);
		tn = -(wide(f) * wide(ak_jb) + wide(e) * wide(jc_al) + wide(d) * wide(bl_kc));
		gn = wide(i) * wide(ak_jb) + wide(h) * wide(jc_al) + wide(g) * wide(bl_kc);
		bn = wide(j) * wide(ei_hf) + wide(k) * wide(gf_di) + wide(l) * wide(dh_eg);
		t = 0;
		if (m == 0) return 0;
		if (m < 0) begin
			m = -m; tn = -tn; gn = -gn; bn = -bn;
		end
		t = q16_wide(tn, m);
		if (t < tmin || t > tmax) return 0;
		if (gn < 0 || gn > m) return 0;
		if (bn < 0 || bn + gn > m) return 0;
		return 1;
	endfunction

	function automatic bit sphere_hit(input longint o[3], input longint dv[3],
			output longint t);
		longint r, ex, ey, ez, bp, dd, cc, s;
		logic signed [127:0] disc;
		r = longint'(cfg_rad);
		ex = o[0] - coord(cfg_ctr, 0);
		ey = o[1] - coord(cfg_ctr, 1);
		ez = o[2] - coord(cfg_ctr, 2);
		bp = dv[0] * ex + dv[1] * ey + dv[2] * ez;
		dd = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
		cc = ex * ex + ey * ey + ez * ez - r * r;
		t = 0;
		if (dd == 0) return 0;
		disc = wide(bp) * wide(bp) - wide(dd) * wide(cc);
		if (disc == 0) begin
			t = q16_short(-bp, dd);
			return 1;
		end
		if (disc < 0) return 0;
		s = root_floor(disc);
		if (-bp - s > 0) begin
			t = q16_short(-bp - s, dd);
			return 1;
		end
		if (-bp + s > 0) begin
			t = q16_short(-bp + s, dd);
			return 1;
		end
		return 0;
	endfunction

	function automatic hit_word_t predict_hit();
		longint o[3], dv[3], t;
		bit h;
		hit_word_t w;
		o[0] = longint'(ray.origin_x); o[1] = longint'(ray.origin_y);
		o[2] = longint'(ray.origin_z);
		dv[0] = longint'(ray.dir_x); dv[1] = longint'(ray.dir_y); dv[2] = longint'(ray.dir_z);
		if (cfg_kind) h = triangle_hit(o, dv, longint'(ray.t_min), longint'(ray.t_max), t);
		else h = sphere_hit(o, dv, t);
		w.hit = h;
		w.t = h ? t[31:0] : MISS_TIME;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_word_t want;
		int push, pop;
		if (!arst_n) begin
			cfg_kind <= 1'b0; cfg_va <= '0; cfg_vb <= '0; cfg_vc <= '0;
			cfg_ctr <= '0; cfg_rad <= '0;
			errors <= 0; pending <= 0; hits_seen <= 0; rays_seen <= 0;
		end else begin
			push = 0; pop = 0;
			if (psel && penable && pwrite && pready) begin
				case (rpi_reg_t'(paddr[PAW-1:3]))
					REG_KIND: cfg_kind <= pwdata[0];
					REG_VA:   cfg_va <= pwdata[RGW-1:0];
					REG_VB:   cfg_vb <= pwdata[RGW-1:0];
					REG_VC:   cfg_vc <= pwdata[RGW-1:0];
					REG_CTR:  cfg_ctr <= pwdata[RGW-1:0];
					REG_RAD:  cfg_rad <= pwdata[RADW-1:0];
					default: ;
				endcase
			end
			if (ray.valid && ray.ready) begin
				hit_q.push_back(predict_hit());
				push = 1;
				rays_seen <= rays_seen + 1;
			end
			if (res.valid && res.ready) begin
				if (hit_q.size() == 0) begin
					$display("%0t: unexpected hit word, got hit=%0b time=%h",
						$time, res.hit, res.hit_time);
					errors <= errors + 1;
				end else begin
					want = hit_q.pop_front();
					pop = 1;
					if (want.hit !== res.hit || want.t !== res.hit_time) begin
						$display("%0t: mismatch, expected hit=%0b time=%h, got hit=%0b time=%h",
							$time, want.hit, want.t, res.hit, res.hit_time);
						errors <= errors + 1;
					end
					if (want.hit) hits_seen <= hits_seen + 1;
				end
			end
			pending <= pending + push - pop;
		end
	end
endmodule

/* tb/tb_ray_primitive_intersection_unit.sv */
// Top of the intersection unit testbench: clock, reset, config writes, ray stimulus, verdict.
module tb_ray_primitive_intersection_unit import rpi_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            psel, penable, pwrite;
	logic [PAW-1:0]  paddr;
	logic [DATW-1:0] pwdata;
	logic [DATW-1:0] prdata;
	logic            pready;
	int              errors, pending, hits_seen, rays_seen;
	int              rdy_mode, rdy_left;
	int              n_tri, n_sph;

	longint va[3], vb[3], vc[3], ctr[3], rad;
	logic   kind;

	rpi_ray_if ray();
	rpi_hit_if res();

	ray_primitive_intersection_unit dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.ray(ray.sink), .res(res.source)
	);

	tb_rpi_checker chk (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.ray(ray), .res(res), .errors, .pending, .hits_seen, .rays_seen
	);

	always #6 clk = ~clk;

	initial begin
		#30ms;
		$display("simulation failed");
		$finish;
	end

	// receiver stalls in stretches of differing character
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= $urandom_range(0, 3);
			rdy_left <= $urandom_range(20, 300);
		end else rdy_left <= rdy_left - 1;
		case (rdy_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= 1'($urandom_range(0, 1));
			2: res.ready <= ($urandom_range(0, 7) != 0);
			default: res.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	function automatic logic [RGW-1:0] pack3(input longint p[3]);
		logic [20:0] x, y, z;
		x = 21'(p[0]); y = 21'(p[1]); z = 21'(p[2]);
		return {z, y, x};
	endfunction

	function automatic longint srnd(input int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic longint full21();
		logic signed [20:0] v;
		v = 21'($urandom());
		return longint'(v);
	endfunction

	function automatic longint clip21(input longint v);
		if (v > 1048575) return 1048575;
		if (v < -1048576) return -1048576;
		return v;
	endfunction

	task automatic reg_write(input rpi_reg_t idx, input logic [DATW-1:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= PAW'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_prim();
		logic [RGW-1:0] a, b, c, s;
		a = pack3(va); b = pack3(vb); c = pack3(vc); s = pack3(ctr);
		reg_write(REG_KIND, {63'd0, kind});
		reg_write(REG_VA, {1'b0, a});
		reg_write(REG_VB, {1'b0, b});
		reg_write(REG_VC, {1'b0, c});
		reg_write(REG_CTR, {1'b0, s});
		reg_write(REG_RAD, 64'(rad[19:0]));
	endtask

	task automatic drain();
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// mode 0 structured, 1 all zero, 2 all ones, 3 fully random bits
	task automatic pick_prim(input logic k, input int mode);
		kind = k;
		for (int n = 0; n < 3; n++) begin
			case (mode)
				0: begin
					va[n] = srnd(131072); vb[n] = srnd(131072); vc[n] = srnd(131072);
					ctr[n] = srnd(131072);
				end
				1: begin va[n] = 0; vb[n] = 0; vc[n] = 0; ctr[n] = 0; end
				2: begin va[n] = -1; vb[n] = -1; vc[n] = -1; ctr[n] = -1; end
				default: begin
					va[n] = full21(); vb[n] = full21(); vc[n] = full21(); ctr[n] = full21();
				end
			endcase
		end
		case (mode)
			0: rad = longint'($urandom_range(1, 200000));
			1: rad = 0;
			2: rad = 64'hFFFFF;
			default: rad = longint'($urandom_range(0, 20'hFFFFF));
		endcase
		load_prim();
	endtask

	task automatic send_ray(input longint o[3], input longint d[3],
			input logic [30:0] tmin, input logic [30:0] tmax);
		int gap, r;
		ray.origin_x <= FW'(o[0]); ray.origin_y <= FW'(o[1]); ray.origin_z <= FW'(o[2]);
		ray.dir_x <= FW'(d[0]); ray.dir_y <= FW'(d[1]); ray.dir_z <= FW'(d[2]);
		ray.t_min <= tmin; ray.t_max <= tmax;
		ray.valid <= 1'b1;
		do @(posedge clk); while (!ray.ready);
		if (kind) n_tri++; else n_sph++;
		r = $urandom_range(0, 99);
		if (r < 60) gap = 0;
		else if (r < 90) gap = $urandom_range(1, 3);
		else if (r < 98) gap = $urandom_range(4, 10);
		else gap = $urandom_range(20, 60);
		if (gap > 0) begin
			ray.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic ray3(input longint ox, oy, oz, dx, dy, dz,
			input longint tmin, input longint tmax);
		longint o[3], d[3];
		o[0] = ox; o[1] = oy; o[2] = oz; d[0] = dx; d[1] = dy; d[2] = dz;
		send_ray(o, d, 31'(tmin), 31'(tmax));
	endtask

	task automatic random_ray();
		longint o[3], d[3], tgt[3], u, v;
		logic [30:0] tmin, tmax;
		int r;
		r = $urandom_range(0, 99);
		tmin = 31'($urandom_range(0, 70000));
		tmax = 31'($urandom_range(60000, 32'h7FFFFFFF));
		if (r < 70) begin
			u = srnd(160) + 128; v = srnd(160) + 128;
			for (int n = 0; n < 3; n++) begin
				o[n] = srnd(262144);
				if (kind) tgt[n] = va[n] + ((vb[n] - va[n]) * u + (vc[n] - va[n]) * v) / 256;
				else tgt[n] = ctr[n] + (rad * srnd(256)) / 128;
				d[n] = clip21(tgt[n] - o[n]);
			end
			if ($urandom_range(0, 9) == 0) tmax = 31'($urandom_range(0, 70000));
		end else if (r < 85) begin
			for (int n = 0; n < 3; n++) begin
				o[n] = srnd(262144); d[n] = srnd(262144);
			end
		end else begin
			for (int n = 0; n < 3; n++) begin
				o[n] = full21(); d[n] = full21();
			end
			tmin = 31'($urandom()); tmax = 31'($urandom());
		end
		send_ray(o, d, tmin, tmax);
	endtask

	initial begin
		ray.valid = 1'b0;
		ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
		ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
		ray.t_min = '0; ray.t_max = '0;
		res.ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		rdy_mode = 0; rdy_left = 0; n_tri = 0; n_sph = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// unit sphere at the origin
		kind = 1'b0;
		for (int n = 0; n < 3; n++) begin va[n] = 0; vb[n] = 0; vc[n] = 0; ctr[n] = 0; end
		rad = 1024;
		load_prim();
		ray3(-4096, 1024, 0, 1024, 0, 0, 0, 0);        // tangent ahead
		ray3(-4096, 1024, 0, -1024, 0, 0, 0, 0);       // tangent behind the origin
		ray3(-4096, 0, 0, 0, 0, 0, 0, 0);              // zero direction
		ray3(0, 0, 0, 1024, 0, 0, 0, 0);               // origin inside
		ray3(-4096, 0, 0, 1024, 0, 0, 0, 0);           // straight through
		ray3(4096, 0, 0, 1024, 0, 0, 0, 0);            // sphere behind
		ray3(-4096, 4096, 0, 1024, 0, 0, 0, 0);        // clean miss
		ray3(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575,
			31'h7FFFFFFF, 31'h7FFFFFFF);
		ray3(1048575, 1048575, 1048575, -1048576, -1048576, -1048576, 0, 0);
		drain();

		// right triangle in the z=0 plane
		kind = 1'b1;
		vb[0] = 2048; vc[1] = 2048;
		load_prim();
		ray3(512, 512, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);     // hit at t=1
		ray3(0, 0, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);         // on a vertex
		ray3(1024, 1024, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);   // on the long edge
		ray3(1536, 1536, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);   // outside
		ray3(512, 512, -1024, 0, 0, 1024, 65536, 65536);        // window exactly t
		ray3(512, 512, -1024, 0, 0, 1024, 65537, 31'h7FFFFFFF); // window past t
		ray3(512, 512, -1024, 0, 0, 1024, 70000, 60000);        // empty window
		ray3(512, 512, 1024, 0, 0, 1024, 0, 31'h7FFFFFFF);      // behind the ray
		ray3(512, 512, -1024, 1024, 0, 0, 0, 31'h7FFFFFFF);     // parallel
		ray3(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575, 0, 31'h7FFFFFFF);
		drain();

		// collinear vertices give a zero determinant
		vc[0] = 4096; vc[1] = 0;
		load_prim();
		ray3(512, 0, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);
		ray3(512, 512, -1024, 0, 0, 1024, 0, 31'h7FFFFFFF);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			int mode;
			mode = (ph < 8) ? 0 : ph - 8;
			pick_prim(ph[0], mode);
			for (int it = 0; it < 153; it++) begin
				if (ph == 5 && it == 70) begin
					ray.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				random_ray();
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("rays tested: %0d triangle, %0d sphere; hits %0d of %0d results",
			n_tri, n_sph, hits_seen, rays_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* ray_primitive_intersection_unit.f */
src/rpi_pkg.sv
src/rpi_if.sv
src/rpi_front.sv
src/rpi_fifo.sv
src/rpi_back.sv
src/ray_primitive_intersection_unit.sv
tb/tb_rpi_checker.sv
tb/tb_ray_primitive_intersection_unit.sv
